// File: src/plps_pkg.sv
// Shared types, constants and a helper function of the Phong point-light shader.
package plps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAG_W      = 30;
    localparam int SUM_W      = 62;
    localparam int LEN_W      = 31;
    localparam int UNIT_W     = 16;
    localparam int LDN14_W    = 17;
    localparam int CHAN_W     = 16;

    localparam logic [CHAN_W-1:0] INTEN_RESET = 16'd4096;
    localparam logic [15:0]       UNIT_ONE    = 16'd16384;
    localparam logic [15:0]       FACTOR_MAX  = 16'hFFFF;
    localparam logic [CHAN_W-1:0] OUT_MAX     = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_POS_X = 3'd0,
        REG_LIGHT_POS_Y = 3'd1,
        REG_LIGHT_POS_Z = 3'd2,
        REG_LIGHT_RED   = 3'd3,
        REG_LIGHT_GREEN = 3'd4,
        REG_LIGHT_BLUE  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [47:0] eye_dir;
        logic [47:0] normal_dir;
        logic [35:0] surface_color;
        logic        shadowed;
        logic [11:0] ambient_coef;
        logic [11:0] diffuse_coef;
        logic [11:0] specular_coef;
        logic [9:0]  shine_exponent;
    } side_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        logic                  zero;
        side_t                 side;
    } norm_t;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0] lv;
        side_t                  side;
    } unit_t;

    typedef struct packed {
        logic               lit;
        logic [LDN14_W-1:0] ldn14;
        logic [15:0]        factor;
        side_t              side;
    } spec_t;

    // Q2.14 product, rounded half up and saturated.
    function automatic logic [15:0] qmul14(input logic [15:0] a, input logic [15:0] b);
        logic [32:0] p;
        logic [18:0] q;
        p = 33'(a) * 33'(b) + 33'd8192;
        q = p[32:14];
        return (q > 19'(FACTOR_MAX)) ? FACTOR_MAX : q[15:0];
    endfunction

endpackage

// File: src/plps_ifs.sv
// Handshake interfaces of the shader: hit items in, shaded colour items out.
interface plps_hit_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [47:0]        eye_dir;
    logic [47:0]        normal_dir;
    logic [35:0]        surface_color;
    logic               shadowed;
    logic [11:0]        ambient_coef;
    logic [11:0]        diffuse_coef;
    logic [11:0]        specular_coef;
    logic [9:0]         shine_exponent;

    modport source (
        output valid, point_x, point_y, point_z, eye_dir, normal_dir, surface_color,
               shadowed, ambient_coef, diffuse_coef, specular_coef, shine_exponent,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, eye_dir, normal_dir, surface_color,
               shadowed, ambient_coef, diffuse_coef, specular_coef, shine_exponent,
        output ready
    );
endinterface

interface plps_shade_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// File: src/plps_light_vec.sv
// Light vector front end: difference, magnitude, common scaling and sum of squares.
module plps_light_vec
    import plps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_vld,
    input  logic [2:0][31:0]      light_pos,
    input  logic [2:0][31:0]      point,
    input  side_t                 in_side,
    output logic                  out_vld,
    output logic [SUM_W-1:0]      out_sum,
    output norm_t                 out_pay
);

    localparam int NSTG = 6;

    logic  vld_reg [NSTG];
    side_t side_reg [NSTG];

    logic [2:0][32:0]       d1_next, d1_reg;
    logic [2:0][32:0]       mag2_next, mag2_reg;
    logic [2:0]             neg2_next, neg2_reg;
    logic [32:0]            mx2_next, mx2_reg;
    logic [2:0][32:0]       mag3_reg;
    logic [2:0]             neg3_reg;
    logic [5:0]             lead3_next, lead3_reg;
    logic                   zero3_next, zero3_reg;
    logic [2:0][MAG_W-1:0]  mag4_next, mag4_reg, mag5_reg, mag6_reg;
    logic [2:0]             neg4_reg, neg5_reg, neg6_reg;
    logic                   zero4_reg, zero5_reg, zero6_reg;
    logic [2:0][59:0]       sq5_next, sq5_reg;
    logic [SUM_W-1:0]       sum6_next, sum6_reg;
    logic [62:0]            wide [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = {light_pos[i][31], light_pos[i]} - {point[i][31], point[i]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg2_next[i] = d1_reg[i][32];
            mag2_next[i] = d1_reg[i][32] ? (33'd0 - d1_reg[i]) : d1_reg[i];
        end
        mx2_next = mag2_next[0];
        if (mag2_next[1] > mx2_next)
        begin
            mx2_next = mag2_next[1];
        end
        if (mag2_next[2] > mx2_next)
        begin
            mx2_next = mag2_next[2];
        end
    end

    always_comb
    begin
        lead3_next = '0;
        for (int b = 0; b < 33; b++)
        begin
            if (mx2_reg[b])
            begin
                lead3_next = 6'(b);
            end
        end
        zero3_next = (mx2_reg == '0);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (lead3_reg >= 6'd29)
            begin
                wide[i] = 63'(mag3_reg[i]) >> (lead3_reg - 6'd29);
            end
            else
            begin
                wide[i] = 63'(mag3_reg[i]) << (6'd29 - lead3_reg);
            end
            mag4_next[i] = wide[i][MAG_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq5_next[i] = 60'(mag4_reg[i]) * 60'(mag4_reg[i]);
        end
        sum6_next = SUM_W'(sq5_reg[0]) + SUM_W'(sq5_reg[1]) + SUM_W'(sq5_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < NSTG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < NSTG; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            d1_reg    <= d1_next;
            mag2_reg  <= mag2_next;
            neg2_reg  <= neg2_next;
            mx2_reg   <= mx2_next;
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            lead3_reg <= lead3_next;
            zero3_reg <= zero3_next;
            mag4_reg  <= mag4_next;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            sq5_reg   <= sq5_next;
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            sum6_reg  <= sum6_next;
            mag6_reg  <= mag5_reg;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    assign out_vld      = vld_reg[NSTG-1];
    assign out_sum      = sum6_reg;
    assign out_pay.neg  = neg6_reg;
    assign out_pay.mag  = mag6_reg;
    assign out_pay.zero = zero6_reg;
    assign out_pay.side = side_reg[NSTG-1];

endmodule

// File: src/plps_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module plps_isqrt
    import plps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [SUM_W-1:0] in_sum,
    input  norm_t            in_pay,
    output logic             out_vld,
    output logic [LEN_W-1:0] out_len,
    output norm_t            out_pay
);

    localparam int STEPS = LEN_W;
    localparam int TW    = SUM_W + 1;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] res;
        norm_t            pay;
    } root_t;

    root_t          st_in [STEPS];
    root_t          st_next [STEPS];
    root_t          st_reg [STEPS];
    logic           vld_in [STEPS];
    logic           vld_reg [STEPS];
    logic [TW-1:0]  trial [STEPS];

    always_comb
    begin
        st_in[0].rem = in_sum;
        st_in[0].res = '0;
        st_in[0].pay = in_pay;
        vld_in[0]    = in_vld;
        for (int s = 1; s < STEPS; s++)
        begin
            st_in[s]  = st_reg[s-1];
            vld_in[s] = vld_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < STEPS; s++)
        begin
            trial[s]   = {1'b0, st_in[s].res} + (TW'(1) << (2 * (STEPS - 1 - s)));
            st_next[s] = st_in[s];
            if ({1'b0, st_in[s].rem} >= trial[s])
            begin
                st_next[s].rem = st_in[s].rem - trial[s][SUM_W-1:0];
                st_next[s].res = (st_in[s].res >> 1) + (SUM_W'(1) << (2 * (STEPS - 1 - s)));
            end
            else
            begin
                st_next[s].res = st_in[s].res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                vld_reg[s] <= vld_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_vld = vld_reg[STEPS-1];
    assign out_len = st_reg[STEPS-1].res[LEN_W-1:0];
    assign out_pay = st_reg[STEPS-1].pay;

endmodule

// File: src/plps_unit_div.sv
// Pipelined restoring dividers that turn the scaled light vector into a Q1.14 unit vector.
module plps_unit_div
    import plps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [LEN_W-1:0] in_len,
    input  norm_t            in_pay,
    output logic             out_vld,
    output unit_t            out_unit
);

    localparam int STEPS = 15;
    localparam int REM_W = MAG_W + 15;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [2:0][REM_W-1:0] rem;
        logic [2:0][STEPS-1:0] quo;
        logic [2:0]            neg;
        logic                  zero;
        side_t                 side;
    } div_t;

    div_t             st_in [STEPS];
    div_t             st_next [STEPS];
    div_t             st_reg [STEPS];
    logic             vld_in [STEPS];
    logic             vld_reg [STEPS];
    logic [REM_W-1:0] dvs [STEPS];

    always_comb
    begin
        st_in[0].len  = in_len;
        st_in[0].quo  = '0;
        st_in[0].neg  = in_pay.neg;
        st_in[0].zero = in_pay.zero;
        st_in[0].side = in_pay.side;
        for (int i = 0; i < 3; i++)
        begin
            st_in[0].rem[i] = (REM_W'(in_pay.mag[i]) << 14) + REM_W'(in_len[LEN_W-1:1]);
        end
        vld_in[0] = in_vld;
        for (int s = 1; s < STEPS; s++)
        begin
            st_in[s]  = st_reg[s-1];
            vld_in[s] = vld_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < STEPS; s++)
        begin
            dvs[s]     = REM_W'(st_in[s].len) << (STEPS - 1 - s);
            st_next[s] = st_in[s];
            for (int i = 0; i < 3; i++)
            begin
                if (st_in[s].rem[i] >= dvs[s])
                begin
                    st_next[s].rem[i] = st_in[s].rem[i] - dvs[s];
                    st_next[s].quo[i] = {st_in[s].quo[i][STEPS-2:0], 1'b1};
                end
                else
                begin
                    st_next[s].quo[i] = {st_in[s].quo[i][STEPS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                vld_reg[s] <= vld_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // A light sitting on the hit point gives the zero vector.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (st_reg[STEPS-1].zero)
            begin
                out_unit.lv[i] = '0;
            end
            else if (st_reg[STEPS-1].neg[i])
            begin
                out_unit.lv[i] = 16'd0 - UNIT_W'(st_reg[STEPS-1].quo[i]);
            end
            else
            begin
                out_unit.lv[i] = UNIT_W'(st_reg[STEPS-1].quo[i]);
            end
        end
        out_unit.side = st_reg[STEPS-1].side;
    end

    assign out_vld = vld_reg[STEPS-1];

endmodule

// File: src/plps_spec.sv
// Dot products, reflection test and specular power by repeated squaring.
module plps_spec
    import plps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_vld,
    input  unit_t in_unit,
    output logic  out_vld,
    output spec_t out_spec
);

    localparam int PSTEPS = 10;

    typedef struct packed {
        logic [15:0]        factor;
        logic [15:0]        base;
        logic               on;
        logic               lit;
        logic [LDN14_W-1:0] ldn14;
        side_t              side;
    } pow_t;

    logic               vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    side_t              side1_reg, side2_reg, side3_reg;
    logic signed [31:0] pln_next [3], ple_next [3], pne_next [3];
    logic signed [31:0] pln_reg [3], ple_reg [3], pne_reg [3];
    logic signed [33:0] ldn2_next, le2_next, ne2_next;
    logic signed [33:0] ldn2_reg, le2_reg, ne2_reg;
    logic signed [17:0] l14s;
    logic signed [51:0] prod3_next, prod3_reg;
    logic signed [33:0] le3_reg;
    logic               lit3_reg;
    logic [LDN14_W-1:0] ldn14_3_reg;
    logic signed [53:0] rde;
    logic [25:0]        upper;
    pow_t               p4_next, p4_reg;
    pow_t               pw_in [PSTEPS];
    pow_t               pw_next [PSTEPS];
    pow_t               pw_reg [PSTEPS];
    logic               pv_in [PSTEPS];
    logic               pv_reg [PSTEPS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pln_next[i] = $signed(in_unit.lv[i]) * $signed(in_unit.side.normal_dir[16*i +: 16]);
            ple_next[i] = $signed(in_unit.lv[i]) * $signed(in_unit.side.eye_dir[16*i +: 16]);
            pne_next[i] = $signed(in_unit.side.normal_dir[16*i +: 16])
                        * $signed(in_unit.side.eye_dir[16*i +: 16]);
        end
        ldn2_next = 34'(pln_reg[0]) + 34'(pln_reg[1]) + 34'(pln_reg[2]);
        le2_next  = 34'(ple_reg[0]) + 34'(ple_reg[1]) + 34'(ple_reg[2]);
        ne2_next  = 34'(pne_reg[0]) + 34'(pne_reg[1]) + 34'(pne_reg[2]);
        l14s       = {1'b0, ldn2_reg[30:14]};
        prod3_next = l14s * ne2_reg;
    end

    // Reflected vector against the eye, Q.42.
    always_comb
    begin
        rde   = {prod3_reg[51], prod3_reg, 1'b0} - {{6{le3_reg[33]}}, le3_reg, 14'd0};
        upper = rde[53:28];
        p4_next.on     = lit3_reg && !rde[53] && (rde != '0);
        p4_next.base   = (upper > 26'(FACTOR_MAX)) ? FACTOR_MAX : upper[15:0];
        p4_next.factor = UNIT_ONE;
        p4_next.lit    = lit3_reg;
        p4_next.ldn14  = ldn14_3_reg;
        p4_next.side   = side3_reg;
    end

    always_comb
    begin
        pw_in[0] = p4_reg;
        pv_in[0] = vld4_reg;
        for (int s = 1; s < PSTEPS; s++)
        begin
            pw_in[s] = pw_reg[s-1];
            pv_in[s] = pv_reg[s-1];
        end
        for (int s = 0; s < PSTEPS; s++)
        begin
            pw_next[s]      = pw_in[s];
            pw_next[s].base = qmul14(pw_in[s].base, pw_in[s].base);
            if (pw_in[s].side.shine_exponent[s])
            begin
                pw_next[s].factor = qmul14(pw_in[s].factor, pw_in[s].base);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            for (int s = 0; s < PSTEPS; s++)
            begin
                pv_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            for (int s = 0; s < PSTEPS; s++)
            begin
                pv_reg[s] <= pv_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pln_reg[i] <= pln_next[i];
                ple_reg[i] <= ple_next[i];
                pne_reg[i] <= pne_next[i];
            end
            side1_reg   <= in_unit.side;
            ldn2_reg    <= ldn2_next;
            le2_reg     <= le2_next;
            ne2_reg     <= ne2_next;
            side2_reg   <= side1_reg;
            prod3_reg   <= prod3_next;
            le3_reg     <= le2_reg;
            lit3_reg    <= !ldn2_reg[33];
            ldn14_3_reg <= ldn2_reg[30:14];
            side3_reg   <= side2_reg;
            p4_reg      <= p4_next;
            for (int s = 0; s < PSTEPS; s++)
            begin
                pw_reg[s] <= pw_next[s];
            end
        end
    end

    assign out_vld         = pv_reg[PSTEPS-1];
    assign out_spec.lit    = pw_reg[PSTEPS-1].lit;
    assign out_spec.ldn14  = pw_reg[PSTEPS-1].ldn14;
    assign out_spec.factor = pw_reg[PSTEPS-1].on ? pw_reg[PSTEPS-1].factor : 16'd0;
    assign out_spec.side   = pw_reg[PSTEPS-1].side;

endmodule

// File: src/plps_color.sv
// Per-channel ambient, diffuse and specular terms, sum and saturation.
module plps_color
    import plps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_vld,
    input  spec_t                  in_spec,
    input  logic [2:0][CHAN_W-1:0] inten,
    output logic                   out_vld,
    output logic [2:0][CHAN_W-1:0] out_chan
);

    logic               vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic [2:0][27:0]   ec1_next, ec1_reg, iks1_next, iks1_reg;
    logic [11:0]        ka1_reg, kd1_reg;
    logic [LDN14_W-1:0] l14_1_reg, l14_2_reg;
    logic [15:0]        fac1_reg;
    logic               on1_reg, on2_reg, on3_reg;
    logic [39:0]        pa [3], pd [3];
    logic [43:0]        ps [3];
    logic [46:0]        pdif [3];
    logic [2:0][29:0]   amb2_next, amb2_reg, amb3_reg, ekd2_next, ekd2_reg;
    logic [2:0][31:0]   sp2_next, sp2_reg, sp3_reg;
    logic [2:0][32:0]   dif3_next, dif3_reg;
    logic [34:0]        total [3];
    logic [2:0][CHAN_W-1:0] out4_next, out4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ec1_next[i]  = 28'(in_spec.side.surface_color[12*i +: 12]) * 28'(inten[i]);
            iks1_next[i] = 28'(inten[i]) * 28'(in_spec.side.specular_coef);
            pa[i]        = 40'(ec1_reg[i]) * 40'(ka1_reg);
            pd[i]        = 40'(ec1_reg[i]) * 40'(kd1_reg);
            ps[i]        = 44'(iks1_reg[i]) * 44'(fac1_reg);
            amb2_next[i] = pa[i][39:10];
            ekd2_next[i] = pd[i][39:10];
            sp2_next[i]  = ps[i][43:12];
            pdif[i]      = 47'(ekd2_reg[i]) * 47'(l14_2_reg);
            dif3_next[i] = pdif[i][46:14];
            total[i]     = 35'(amb3_reg[i]);
            if (on3_reg)
            begin
                total[i] = total[i] + 35'(dif3_reg[i]) + 35'(sp3_reg[i]);
            end
            out4_next[i] = (total[i][34:28] != '0) ? OUT_MAX : total[i][27:12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ec1_reg   <= ec1_next;
            iks1_reg  <= iks1_next;
            ka1_reg   <= in_spec.side.ambient_coef;
            kd1_reg   <= in_spec.side.diffuse_coef;
            l14_1_reg <= in_spec.ldn14;
            fac1_reg  <= in_spec.factor;
            on1_reg   <= in_spec.lit && !in_spec.side.shadowed;
            amb2_reg  <= amb2_next;
            ekd2_reg  <= ekd2_next;
            sp2_reg   <= sp2_next;
            l14_2_reg <= l14_1_reg;
            on2_reg   <= on1_reg;
            dif3_reg  <= dif3_next;
            amb3_reg  <= amb2_reg;
            sp3_reg   <= sp2_reg;
            on3_reg   <= on2_reg;
            out4_reg  <= out4_next;
        end
    end

    assign out_vld  = vld4_reg;
    assign out_chan = out4_reg;

endmodule

// File: src/phong_point_light_shader.sv
// Top level of the Phong point-light shader: configuration registers and pipeline.
//
//  Channel  Direction  Handshake            Carries
//  hit      in         valid/ready          hit point, eye, normal, colour, material
//  shade    out        valid/ready          shaded red, green and blue, Q4.12
//  cfg      in         cfg_wr_en            light position and intensity registers
//
// One item is accepted in every cycle unless the pipeline holds; the pipeline includes
// the 31 square-root stages, the 15 divider stages and the 10 power stages.
// Reset clears every valid bit and loads the light registers with their reset values.
// When a finished result is not taken, the whole pipeline holds and no item is accepted.
module phong_point_light_shader
    import plps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    plps_hit_if.sink              hit,
    plps_shade_if.source          shade,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [31:0]            light_pos_x_reg, light_pos_y_reg, light_pos_z_reg;
    logic [CHAN_W-1:0]      light_red_reg, light_green_reg, light_blue_reg;
    logic                   adv;
    side_t                  in_side;
    logic                   lv_vld, sq_vld, dv_vld, sp_vld, col_vld;
    logic [SUM_W-1:0]       lv_sum;
    norm_t                  lv_pay, sq_pay;
    logic [LEN_W-1:0]       sq_len;
    unit_t                  dv_unit;
    spec_t                  sp_pay;
    logic [2:0][CHAN_W-1:0] col_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_pos_x_reg <= '0;
            light_pos_y_reg <= '0;
            light_pos_z_reg <= '0;
            light_red_reg   <= INTEN_RESET;
            light_green_reg <= INTEN_RESET;
            light_blue_reg  <= INTEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LIGHT_POS_X: light_pos_x_reg <= cfg_data;
                REG_LIGHT_POS_Y: light_pos_y_reg <= cfg_data;
                REG_LIGHT_POS_Z: light_pos_z_reg <= cfg_data;
                REG_LIGHT_RED:   light_red_reg   <= cfg_data[CHAN_W-1:0];
                REG_LIGHT_GREEN: light_green_reg <= cfg_data[CHAN_W-1:0];
                REG_LIGHT_BLUE:  light_blue_reg  <= cfg_data[CHAN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign adv       = !col_vld || shade.ready;
    assign hit.ready = adv;

    assign in_side.eye_dir        = hit.eye_dir;
    assign in_side.normal_dir     = hit.normal_dir;
    assign in_side.surface_color  = hit.surface_color;
    assign in_side.shadowed       = hit.shadowed;
    assign in_side.ambient_coef   = hit.ambient_coef;
    assign in_side.diffuse_coef   = hit.diffuse_coef;
    assign in_side.specular_coef  = hit.specular_coef;
    assign in_side.shine_exponent = hit.shine_exponent;

    plps_light_vec u_light_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (hit.valid),
        .light_pos ({light_pos_z_reg, light_pos_y_reg, light_pos_x_reg}),
        .point     ({hit.point_z, hit.point_y, hit.point_x}),
        .in_side   (in_side),
        .out_vld   (lv_vld),
        .out_sum   (lv_sum),
        .out_pay   (lv_pay)
    );

    plps_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (lv_vld),
        .in_sum  (lv_sum),
        .in_pay  (lv_pay),
        .out_vld (sq_vld),
        .out_len (sq_len),
        .out_pay (sq_pay)
    );

    plps_unit_div u_unit_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (sq_vld),
        .in_len   (sq_len),
        .in_pay   (sq_pay),
        .out_vld  (dv_vld),
        .out_unit (dv_unit)
    );

    plps_spec u_spec (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (dv_vld),
        .in_unit  (dv_unit),
        .out_vld  (sp_vld),
        .out_spec (sp_pay)
    );

    plps_color u_color (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (sp_vld),
        .in_spec  (sp_pay),
        .inten    ({light_blue_reg, light_green_reg, light_red_reg}),
        .out_vld  (col_vld),
        .out_chan (col_out)
    );

    assign shade.valid     = col_vld;
    assign shade.out_red   = col_out[0];
    assign shade.out_green = col_out[1];
    assign shade.out_blue  = col_out[2];

    a_len_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld && !sq_pay.zero |-> sq_len[LEN_W-1:LEN_W-2] != 2'b00)
        else $error("Vector length below the scaled range.");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld |-> ($signed(dv_unit.lv[0]) <= 16'sd16384 && $signed(dv_unit.lv[0]) >= -16'sd16384
                 && $signed(dv_unit.lv[1]) <= 16'sd16384 && $signed(dv_unit.lv[1]) >= -16'sd16384
                 && $signed(dv_unit.lv[2]) <= 16'sd16384 && $signed(dv_unit.lv[2]) >= -16'sd16384))
        else $error("Unit vector component out of range.");

    a_unlit_no_spec: assert property (@(posedge clk) disable iff (!rst_n)
        sp_vld && !sp_pay.lit |-> sp_pay.factor == 16'd0)
        else $error("Specular factor present for an unlit item.");

endmodule

// File: tb/plps_shade_checker.sv
// Checker of the shader: predicts each shaded colour from accepted hit items and compares.
module plps_shade_checker
    import plps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    plps_hit_if                   hit,
    plps_shade_if                 shade,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    shaded_seen
);

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } colour_t;

    colour_t     colour_q[$];
    logic [31:0] lpos[3];
    logic [15:0] inten[3];

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] q14_product(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = (a * b + 64'd8192) >> 14;
        return (p > 64'd65535) ? 64'd65535 : p;
    endfunction

    function automatic colour_t shade_hit(
        input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
        input logic [47:0] eye, input logic [47:0] nrm, input logic [35:0] col,
        input logic shad, input logic [11:0] ka, input logic [11:0] kd,
        input logic [11:0] ks, input logic [9:0] shine);
        longint      d[3];
        longint      lv[3];
        longint      nv[3];
        longint      ev[3];
        logic [63:0] mag[3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] ldn14;
        logic [63:0] factor;
        logic [63:0] base;
        logic [63:0] ec;
        logic [63:0] total;
        logic [63:0] chan[3];
        logic [9:0]  e;
        longint      ldn;
        longint      le;
        longint      ne;
        longint      rde;
        longint      u;
        logic        lit;
        colour_t     r;
        d[0] = longint'($signed(lpos[0])) - longint'($signed(px));
        d[1] = longint'($signed(lpos[1])) - longint'($signed(py));
        d[2] = longint'($signed(lpos[2])) - longint'($signed(pz));
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = d[i] < 0 ? -d[i] : d[i];
            if (mag[i] > mx)
                mx = mag[i];
            ev[i] = longint'($signed(eye[16*i +: 16]));
            nv[i] = longint'($signed(nrm[16*i +: 16]));
            lv[i] = 0;
        end
        if (mx != 0)
        begin
            while (mx >= (64'd1 << 30))
            begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] >> 1;
            end
            while (mx < (64'd1 << 29))
            begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
            end
            len = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int i = 0; i < 3; i++)
            begin
                u = ((mag[i] << 14) + len / 2) / len;
                lv[i] = d[i] < 0 ? -u : u;
            end
        end
        ldn = lv[0] * nv[0] + lv[1] * nv[1] + lv[2] * nv[2];
        le = lv[0] * ev[0] + lv[1] * ev[1] + lv[2] * ev[2];
        ne = nv[0] * ev[0] + nv[1] * ev[1] + nv[2] * ev[2];
        ldn14 = 0;
        factor = 0;
        lit = ldn >= 0;
        if (lit)
        begin
            ldn14 = ldn >>> 14;
            rde = -le * 16384 + 2 * longint'(ldn14) * ne;
            if (rde > 0)
            begin
                base = rde >>> 28;
                if (base > 64'd65535)
                    base = 64'd65535;
                e = shine;
                factor = 64'd16384;
                while (e != 0)
                begin
                    if (e[0])
                        factor = q14_product(factor, base);
                    base = q14_product(base, base);
                    e = e >> 1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            ec = 64'(col[12*i +: 12]) * 64'(inten[i]);
            total = (ec * ka) >> 10;
            if (!shad && lit)
            begin
                total = total + ((((ec * kd) >> 10) * ldn14) >> 14);
                total = total + ((64'(inten[i]) * ks * factor) >> 12);
            end
            total = total >> 12;
            chan[i] = total > 64'd65535 ? 64'd65535 : total;
        end
        r.red = chan[0][15:0];
        r.green = chan[1][15:0];
        r.blue = chan[2][15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        colour_t want;
        if (!rst_n)
        begin
            lpos[0] = 0;
            lpos[1] = 0;
            lpos[2] = 0;
            inten[0] = INTEN_RESET;
            inten[1] = INTEN_RESET;
            inten[2] = INTEN_RESET;
            colour_q.delete();
            fail_count = 0;
            shaded_seen = 0;
            pending = 0;
        end
        else
        begin
            if (hit.valid && hit.ready)
                colour_q.push_back(shade_hit(hit.point_x, hit.point_y, hit.point_z,
                    hit.eye_dir, hit.normal_dir, hit.surface_color, hit.shadowed,
                    hit.ambient_coef, hit.diffuse_coef, hit.specular_coef,
                    hit.shine_exponent));
            if (shade.valid && shade.ready)
            begin
                shaded_seen++;
                if (colour_q.size() == 0)
                begin
                    $display("shaded item arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = colour_q.pop_front();
                    if (shade.out_red !== want.red)
                        report_mismatch("red", shade.out_red, want.red);
                    if (shade.out_green !== want.green)
                        report_mismatch("green", shade.out_green, want.green);
                    if (shade.out_blue !== want.blue)
                        report_mismatch("blue", shade.out_blue, want.blue);
                end
            end
            pending = colour_q.size();
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_LIGHT_POS_X: lpos[0] = cfg_data;
                    REG_LIGHT_POS_Y: lpos[1] = cfg_data;
                    REG_LIGHT_POS_Z: lpos[2] = cfg_data;
                    REG_LIGHT_RED:   inten[0] = cfg_data[15:0];
                    REG_LIGHT_GREEN: inten[1] = cfg_data[15:0];
                    REG_LIGHT_BLUE:  inten[2] = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: tb/phong_point_light_shader_tb.sv
// Testbench top of the shader: drives hit items and light settings and gives the verdict.
module phong_point_light_shader_tb;
    import plps_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    shaded_seen;
    int                    sent;
    int                    stall_mode;

    plps_hit_if   hit();
    plps_shade_if shade();

    phong_point_light_shader dut (
        .clk(clk), .rst_n(rst_n), .hit(hit), .shade(shade),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    plps_shade_checker checker_i (
        .clk(clk), .rst_n(rst_n), .hit(hit), .shade(shade),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .shaded_seen(shaded_seen)
    );

    initial
    begin
        clk = 0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shade.ready <= 1'b0;
        else
            case (stall_mode)
                0: shade.ready <= 1'b1;
                1: shade.ready <= ($urandom_range(0, 3) != 0);
                default: shade.ready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [15:0] unit_part();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF;
            default: return 32'($urandom_range(0, 20'hFFFFF)) - 32'h80000;
        endcase
    endfunction

    // Sends one item and holds it until the block takes it.
    task automatic send_hit(
        input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
        input logic [47:0] eye, input logic [47:0] nrm, input logic [35:0] col,
        input logic shad, input logic [11:0] ka, input logic [11:0] kd,
        input logic [11:0] ks, input logic [9:0] shine);
        hit.valid <= 1'b1;
        hit.point_x <= px;
        hit.point_y <= py;
        hit.point_z <= pz;
        hit.eye_dir <= eye;
        hit.normal_dir <= nrm;
        hit.surface_color <= col;
        hit.shadowed <= shad;
        hit.ambient_coef <= ka;
        hit.diffuse_coef <= kd;
        hit.specular_coef <= ks;
        hit.shine_exponent <= shine;
        @(posedge clk);
        while (!hit.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_random_hit();
        logic [47:0] eye;
        logic [47:0] nrm;
        eye = {unit_part(), unit_part(), unit_part()};
        nrm = {unit_part(), unit_part(), unit_part()};
        if ($urandom_range(0, 3) == 0)
            eye = 48'({$urandom, $urandom});
        send_hit(coord(), coord(), coord(), eye, nrm, {$urandom, 4'($urandom)},
                 $urandom_range(0, 4) == 0, 12'($urandom), 12'($urandom),
                 12'($urandom), $urandom_range(0, 7) == 0 ? 10'($urandom)
                 : 10'($urandom_range(0, 64)));
    endtask

    task automatic random_phase(input int count);
        int burst;
        int n;
        int gap;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst && n < count; j++)
            begin
                send_random_hit();
                n++;
            end
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                hit.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        hit.valid <= 1'b0;
    endtask

    task automatic set_light(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b);
        write_reg(REG_LIGHT_POS_X, x);
        write_reg(REG_LIGHT_POS_Y, y);
        write_reg(REG_LIGHT_POS_Z, z);
        write_reg(REG_LIGHT_RED, {16'h0, r});
        write_reg(REG_LIGHT_GREEN, {16'h0, g});
        write_reg(REG_LIGHT_BLUE, {16'h0, b});
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n = 0;
        stall_mode = 0;
        sent = 0;
        cfg_wr_en = 0;
        cfg_index = '0;
        cfg_data = '0;
        hit.valid = 0;
        hit.point_x = 0;
        hit.point_y = 0;
        hit.point_z = 0;
        hit.eye_dir = 0;
        hit.normal_dir = 0;
        hit.surface_color = 0;
        hit.shadowed = 0;
        hit.ambient_coef = 0;
        hit.diffuse_coef = 0;
        hit.specular_coef = 0;
        hit.shine_exponent = 0;
        repeat (7) @(posedge clk);
        rst_n = 1;
        @(posedge clk);

        // Directed items under the reset light, which sits at the origin.
        send_hit(0, 0, 0, {16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd16384},
                 36'hFFF_FFF_FFF, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 10'd1);
        send_hit(0, 0, 32'hFFFF0000, {16'd0, 16'd0, 16'd16384},
                 {16'd0, 16'd0, 16'd16384}, 36'hFFF_FFF_FFF, 1'b0, 12'd1024, 12'd1024,
                 12'd1024, 10'd0);
        send_hit(0, 0, 32'hFFFF0000, {16'd0, 16'd0, 16'd16384},
                 {16'd0, 16'd0, 16'd16384}, 36'hFFF_FFF_FFF, 1'b1, 12'd1024, 12'd1024,
                 12'd1024, 10'd10);
        send_hit(0, 0, 32'h00010000, {16'd0, 16'd0, 16'd16384},
                 {16'd0, 16'd0, 16'd16384}, 36'h800_400_200, 1'b0, 12'd100, 12'd800,
                 12'd900, 10'd1023);
        send_hit(32'h80000000, 32'h80000000, 32'h80000000, 48'hFFFF_FFFF_FFFF,
                 48'h8000_8000_8000, 36'hFFF_000_FFF, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF,
                 10'd3);
        send_hit(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'h7FFF_7FFF_7FFF,
                 48'h8000_8000_8000, 36'h000_FFF_000, 1'b0, 12'd0, 12'd0, 12'd0,
                 10'd512);
        send_hit(32'h00020000, 0, 32'hFFFE0000, 48'h7FFF_7FFF_7FFF,
                 48'h7FFF_7FFF_7FFF, 36'hFFF_FFF_FFF, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF,
                 10'd2);
        hit.valid <= 1'b0;
        wait_idle();

        set_light(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        stall_mode = 1;
        send_hit(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 48'h0000_0000_4000,
                 48'h0000_0000_4000, 36'hFFF_FFF_FFF, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF,
                 10'd1);
        send_hit(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 48'h0000_0000_4000,
                 48'h0000_0000_4000, 36'hFFF_FFF_FFF, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF,
                 10'd1);
        random_phase(300);
        wait_idle();

        set_light(32'h00050000, 32'h000A0000, 32'hFFF60000, 16'd0, 16'd2048, 16'd4096);
        stall_mode = 2;
        random_phase(300);
        wait_idle();

        set_light($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom));
        stall_mode = 0;
        random_phase(200);
        wait_idle();
        stall_mode = 1;
        random_phase(200);
        wait_idle();

        $display("Sent %0d hit items over four light settings; %0d shaded items checked.",
                 sent, shaded_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
